// ===== rtl/tpd_pkg.sv =====
// Shared types and constants of the trigger packet deframer.
package tpd_pkg;

  typedef enum logic [1:0] {
    PhHeader,
    PhTail,
    PhEvent,
    PhLong
  } tpd_phase_e;

  localparam logic [7:0] SourceReset = 8'h30;

  localparam logic KindEvent = 1'b0;
  localparam logic KindError = 1'b1;

  localparam int unsigned QueueDepth = 2;

  // One classified item handed from the parser to the arithmetic stage.
  typedef struct packed {
    logic        kind;
    logic [15:0] prim;
    logic [7:0]  fine;
    logic [31:0] et;
    logic [23:0] pt;
    logic        is_long;
    logic        last;
  } tpd_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpd_q_status_t;

endpackage

// ===== rtl/tpd_if.sv =====
// Valid/ready channel interfaces of the trigger packet deframer.
interface tpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface tpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_source;

  modport source (output valid, output expected_source, input ready);
  modport sink (input valid, input expected_source, output ready);
endinterface

interface tpd_result_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [15:0]        primitive_id;
  logic [7:0]         fine_time;
  logic [31:0]        event_time;
  logic signed [32:0] packet_offset;
  logic signed [40:0] time_delta;
  logic               long_form;
  logic               last_in_packet;

  modport source (
    output valid, output result_kind, output primitive_id, output fine_time,
    output event_time, output packet_offset, output time_delta,
    output long_form, output last_in_packet, input ready
  );
  modport sink (
    input valid, input result_kind, input primitive_id, input fine_time,
    input event_time, input packet_offset, input time_delta,
    input long_form, input last_in_packet, output ready
  );
endinterface

// ===== rtl/trigger_packet_deframer_unit.sv =====
// Top level of the trigger packet deframer: parser, record queue and result stage.
// Takes one stream byte per clock while the two-entry record queue has room.
// A result for an event or a header error goes into the queue and then into the result
// register of the arithmetic stage, where it is held while result_o.ready is low.
// Reset clears the parser to the start of a header, the source register to 0x30,
// the previous event time and fine time to zero and empties the queue.
module trigger_packet_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpd_byte_if.sink    byte_i,
  tpd_cfg_if.sink     cfg_i,
  tpd_result_if.source result_o
);
  import tpd_pkg::*;

  logic          push, pop;
  tpd_rec_t      rec_in, rec_out;
  tpd_q_status_t q_status;

  tpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .cfg_i      (cfg_i),
    .q_status_i (q_status),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  tpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (rec_in),
    .pop_i    (pop),
    .rec_o    (rec_out),
    .status_o (q_status)
  );

  tpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rec_out),
    .q_status_i (q_status),
    .pop_o      (pop),
    .result_o   (result_o)
  );

`ifndef NO_ASSERTIONS
  // Once the error beat has gone out the block is halted and stays silent.
  a_silent_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.result_kind == KindError)
    |=> !result_o.valid)
    else $error("result after error beat");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.result_kind == KindError)
    |-> (result_o.primitive_id == '0 && result_o.event_time == '0 &&
         result_o.packet_offset == '0 && result_o.time_delta == '0 &&
         result_o.fine_time == '0 && !result_o.long_form && !result_o.last_in_packet))
    else $error("error beat carries event fields");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");
`endif

endmodule

// ===== rtl/tpd_front.sv =====
// Byte parser: walks headers and events and queues one record per event or error.
module tpd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tpd_byte_if.sink              byte_i,
  tpd_cfg_if.sink               cfg_i,
  input  tpd_pkg::tpd_q_status_t q_status_i,
  output logic                  push_o,
  output tpd_pkg::tpd_rec_t     rec_o
);
  import tpd_pkg::*;

  tpd_phase_e  phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic        retry_q, retry_d;
  logic        halted_q, halted_d;
  logic [7:0]  left_q, left_d;
  logic [23:0] pt_q, pt_d;
  logic [23:0] hts_q, hts_d;
  logic [7:0]  expected_q;
  logic [7:0]  win_q [3];
  logic [7:0]  win_d [3];
  logic [7:0]  evb_q [3];
  logic [7:0]  evb_d [3];
  logic        acc;
  logic [7:0]  b;

  assign byte_i.ready = !q_status_i.full;
  assign cfg_i.ready  = 1'b1;
  assign acc          = byte_i.valid && byte_i.ready;
  assign b            = byte_i.stream_byte;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    retry_d  = retry_q;
    halted_d = halted_q;
    left_d   = left_q;
    pt_d     = pt_q;
    hts_d    = hts_q;
    win_d    = win_q;
    evb_d    = evb_q;
    push_o   = 1'b0;

    rec_o.kind    = KindEvent;
    rec_o.prim    = {b, evb_q[2]};
    rec_o.fine    = evb_q[0];
    rec_o.et      = {hts_q, evb_q[1]};
    rec_o.pt      = pt_q;
    rec_o.is_long = (phase_q == PhLong);
    rec_o.last    = (left_q == 8'd1);

    if (acc && !halted_q) begin
      unique case (phase_q)
        PhHeader: begin
          if (pos_q != 2'd3) begin
            win_d[pos_q] = b;
            pos_d        = pos_q + 2'd1;
          end else if (b == expected_q) begin
            pt_d    = {win_q[2], win_q[1], win_q[0]};
            phase_d = PhTail;
            pos_d   = 2'd0;
          end else if (!retry_q) begin
            // Slide the header window by two bytes and look again.
            win_d[0] = win_q[2];
            win_d[1] = b;
            pos_d    = 2'd2;
            retry_d  = 1'b1;
          end else begin
            halted_d   = 1'b1;
            push_o     = 1'b1;
            rec_o      = '0;
            rec_o.kind = KindError;
          end
        end
        PhTail: begin
          if (pos_q == 2'd2) begin
            left_d = b;
          end
          if (pos_q != 2'd3) begin
            pos_d = pos_q + 2'd1;
          end else if (left_q == 8'd0) begin
            phase_d = PhHeader;
            pos_d   = 2'd0;
            retry_d = 1'b0;
          end else begin
            phase_d = PhEvent;
            pos_d   = 2'd0;
          end
        end
        PhEvent, PhLong: begin
          if (pos_q != 2'd3) begin
            evb_d[pos_q] = b;
            pos_d        = pos_q + 2'd1;
          end else if (phase_q == PhEvent && b == 8'd0) begin
            // A zero top byte carries a new high timestamp; the event follows.
            hts_d   = {evb_q[2], evb_q[1], evb_q[0]};
            phase_d = PhLong;
            pos_d   = 2'd0;
          end else begin
            push_o = 1'b1;
            left_d = left_q - 8'd1;
            pos_d  = 2'd0;
            if (left_q == 8'd1) begin
              phase_d = PhHeader;
              retry_d = 1'b0;
            end else begin
              phase_d = PhEvent;
            end
          end
        end
        default: begin
          phase_d = PhHeader;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      pos_q      <= 2'd0;
      retry_q    <= 1'b0;
      halted_q   <= 1'b0;
      left_q     <= 8'd0;
      pt_q       <= 24'd0;
      hts_q      <= 24'd0;
      expected_q <= SourceReset;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      retry_q  <= retry_d;
      halted_q <= halted_d;
      left_q   <= left_d;
      pt_q     <= pt_d;
      hts_q    <= hts_d;
      if (cfg_i.valid && cfg_i.ready) begin
        expected_q <= cfg_i.expected_source;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    evb_q <= evb_d;
  end

endmodule

// ===== rtl/tpd_queue.sv =====
// Short record queue between the parser and the arithmetic stage.
module tpd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tpd_pkg::tpd_rec_t      rec_i,
  input  logic                   pop_i,
  output tpd_pkg::tpd_rec_t      rec_o,
  output tpd_pkg::tpd_q_status_t status_o
);
  import tpd_pkg::*;

  localparam int unsigned AddrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(QueueDepth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(QueueDepth);

  tpd_rec_t          slot_q [QueueDepth];
  logic [AddrW-1:0]  wr_q, rd_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == FullCount);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rec_o          = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= rec_i;
    end
  end

endmodule

// ===== rtl/tpd_back.sv =====
// Arithmetic stage: forms offset and delta and holds the result register.
module tpd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tpd_pkg::tpd_rec_t      rec_i,
  input  tpd_pkg::tpd_q_status_t q_status_i,
  output logic                   pop_o,
  tpd_result_if.source           result_o
);
  import tpd_pkg::*;

  logic               vld_q;
  logic [31:0]        prev_time_q;
  logic [7:0]         prev_fine_q;
  logic               kind_q;
  logic [15:0]        prim_q;
  logic [7:0]         fine_q;
  logic [31:0]        et_q;
  logic signed [32:0] offset_q;
  logic signed [40:0] delta_q;
  logic               long_q;
  logic               last_q;
  logic [32:0]        offset_d;
  logic [32:0]        tdiff;
  logic [40:0]        delta_d;
  logic               is_event;

  assign pop_o    = !q_status_i.empty && (!vld_q || result_o.ready);
  assign is_event = (rec_i.kind == KindEvent);

  always_comb begin
    offset_d = {1'b0, rec_i.pt, 8'd0} - {1'b0, rec_i.et};
    tdiff    = {1'b0, rec_i.et} - {1'b0, prev_time_q};
    delta_d  = {tdiff, 8'd0} + {33'd0, rec_i.fine} - {33'd0, prev_fine_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= 1'b0;
      prev_time_q <= 32'd0;
      prev_fine_q <= 8'd0;
    end else begin
      if (pop_o) begin
        vld_q <= 1'b1;
      end else if (result_o.ready) begin
        vld_q <= 1'b0;
      end
      if (pop_o && is_event) begin
        prev_time_q <= rec_i.et;
        prev_fine_q <= rec_i.fine;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= rec_i.kind;
      if (is_event) begin
        prim_q   <= rec_i.prim;
        fine_q   <= rec_i.fine;
        et_q     <= rec_i.et;
        offset_q <= signed'(offset_d);
        delta_q  <= signed'(delta_d);
        long_q   <= rec_i.is_long;
        last_q   <= rec_i.last;
      end else begin
        prim_q   <= '0;
        fine_q   <= '0;
        et_q     <= '0;
        offset_q <= '0;
        delta_q  <= '0;
        long_q   <= 1'b0;
        last_q   <= 1'b0;
      end
    end
  end

  assign result_o.valid          = vld_q;
  assign result_o.result_kind    = kind_q;
  assign result_o.primitive_id   = prim_q;
  assign result_o.fine_time      = fine_q;
  assign result_o.event_time     = et_q;
  assign result_o.packet_offset  = offset_q;
  assign result_o.time_delta     = delta_q;
  assign result_o.long_form      = long_q;
  assign result_o.last_in_packet = last_q;

endmodule
